// ===== sv/tmt_pkg.sv =====
// Shared types, codes and helpers of the text map tokenizer.
// Used by the front end, the queue, the back end and the top level.
package tmt_pkg;

  localparam int MAX_RES = 5;
  localparam int CNT_W = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] EV_BYTE = 2'd0;
  localparam logic [1:0] EV_END = 2'd1;
  localparam logic [1:0] EV_EOS = 2'd2;

  localparam logic [1:0] CLS_STRING = 2'd0;
  localparam logic [1:0] CLS_WORD = 2'd1;
  localparam logic [1:0] CLS_SYMBOL = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DEL = 8'd127;
  localparam logic [7:0] CH_NBSP = 8'd160;
  localparam logic [7:0] CH_STAR = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_NL = 8'h0a;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS = 8'h2b;
  localparam logic [7:0] CH_DOT = 8'h2e;

  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_WORD       = 3'd1,
    MODE_STR        = 3'd2,
    MODE_STR_ESC    = 3'd3,
    MODE_BLOCK      = 3'd4,
    MODE_BLOCK_STAR = 3'd5,
    MODE_LINE       = 3'd6
  } mode_t;

  typedef struct packed {
    logic [1:0] ev;
    logic [7:0] tbyte;
    logic [1:0] cls;
    logic       first;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]          cnt;
    res_t [MAX_RES-1:0]        res;
  } entry_t;

  function automatic logic is_space(logic [7:0] b);
    return (b <= CH_SPACE) || (b >= CH_DEL && b <= CH_NBSP);
  endfunction

  function automatic logic is_word_start(logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
           (b >= 8'h61 && b <= 8'h7a) || b == CH_UNDER || b == CH_MINUS ||
           b == CH_PLUS;
  endfunction

  function automatic entry_t put(entry_t e, logic [1:0] ev, logic [7:0] b,
                                 logic [1:0] cls, logic first);
    entry_t r;
    r = e;
    if (r.cnt < CNT_W'(MAX_RES)) begin
      r.res[r.cnt] = '{ev: ev, tbyte: b, cls: cls, first: first};
      r.cnt = r.cnt + 1'b1;
    end
    return r;
  endfunction

  function automatic entry_t put_symbol(entry_t e, logic [7:0] b);
    entry_t r;
    r = put(e, EV_BYTE, b, CLS_SYMBOL, 1'b1);
    r = put(r, EV_END, 8'd0, CLS_SYMBOL, 1'b0);
    return r;
  endfunction

  function automatic entry_t between(entry_t e, logic [7:0] b);
    entry_t r;
    r = e;
    if (!is_space(b) && b != CH_SLASH) begin
      if (b == CH_QUOTE) begin
        r = put(r, EV_BYTE, b, CLS_STRING, 1'b1);
      end else if (is_word_start(b)) begin
        r = put(r, EV_BYTE, b, CLS_WORD, 1'b1);
      end else begin
        r = put_symbol(r, b);
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/tmt_front.sv =====
// Front end of the tokenizer: lexer state and classification of each byte.
// Builds the full list of token words for one byte. Depends on tmt_pkg.
module tmt_front import tmt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       acc,
  input  logic [7:0] data_byte,
  input  logic       end_of_input,
  output logic       push,
  output entry_t     entry
);

  mode_t      mode, mode_step, mode_next;
  logic       sp, sp_step, sp_next;
  logic [1:0] oc, oc_step, oc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      sp   <= 1'b0;
      oc   <= CLS_STRING;
    end else if (acc) begin
      mode <= mode_next;
      sp   <= sp_next;
      oc   <= oc_next;
    end
  end

  always_comb begin
    logic go_between;
    mode_step  = mode;
    sp_step    = sp;
    oc_step    = oc;
    go_between = 1'b0;
    unique case (mode)
      MODE_WORD: begin
        if (!(is_word_start(data_byte) || data_byte == CH_DOT)) begin
          mode_step  = MODE_NORMAL;
          oc_step    = CLS_STRING;
          go_between = 1'b1;
        end
      end
      MODE_STR: begin
        if (data_byte == CH_BSLASH) begin
          mode_step = MODE_STR_ESC;
        end else if (data_byte == CH_QUOTE) begin
          mode_step = MODE_NORMAL;
          oc_step   = CLS_STRING;
        end
      end
      MODE_STR_ESC: mode_step = MODE_STR;
      MODE_BLOCK: begin
        if (data_byte == CH_STAR) mode_step = MODE_BLOCK_STAR;
      end
      MODE_BLOCK_STAR: begin
        if (data_byte == CH_SLASH) mode_step = MODE_NORMAL;
        else if (data_byte != CH_STAR) mode_step = MODE_BLOCK;
      end
      MODE_LINE: begin
        if (data_byte == CH_NL) mode_step = MODE_NORMAL;
      end
      default: begin
        mode_step = MODE_NORMAL;
        if (sp) begin
          sp_step = 1'b0;
          if (data_byte == CH_STAR) mode_step = MODE_BLOCK;
          else if (data_byte == CH_SLASH) mode_step = MODE_LINE;
          else go_between = 1'b1;
        end else begin
          go_between = 1'b1;
        end
      end
    endcase
    if (go_between && !is_space(data_byte)) begin
      if (data_byte == CH_SLASH) begin
        sp_step = 1'b1;
      end else if (data_byte == CH_QUOTE) begin
        mode_step = MODE_STR;
        oc_step   = CLS_STRING;
      end else if (is_word_start(data_byte)) begin
        mode_step = MODE_WORD;
        oc_step   = CLS_WORD;
      end
    end
    mode_next = end_of_input ? MODE_NORMAL : mode_step;
    sp_next   = end_of_input ? 1'b0 : sp_step;
    oc_next   = end_of_input ? CLS_STRING : oc_step;
  end

  always_comb begin
    entry_t e;
    e = '0;
    unique case (mode) inside
      MODE_WORD: begin
        if (is_word_start(data_byte) || data_byte == CH_DOT) begin
          e = put(e, EV_BYTE, data_byte, CLS_WORD, 1'b0);
        end else begin
          e = put(e, EV_END, 8'd0, CLS_WORD, 1'b0);
          e = between(e, data_byte);
        end
      end
      MODE_STR: begin
        e = put(e, EV_BYTE, data_byte, CLS_STRING, 1'b0);
        if (data_byte == CH_QUOTE) e = put(e, EV_END, 8'd0, CLS_STRING, 1'b0);
      end
      MODE_STR_ESC: e = put(e, EV_BYTE, data_byte, CLS_STRING, 1'b0);
      MODE_BLOCK, MODE_BLOCK_STAR, MODE_LINE: e = '0;
      default: begin
        if (sp) begin
          if (data_byte != CH_STAR && data_byte != CH_SLASH) begin
            e = put_symbol(e, CH_SLASH);
            e = between(e, data_byte);
          end
        end else begin
          e = between(e, data_byte);
        end
      end
    endcase
    if (end_of_input) begin
      if (sp_step) e = put_symbol(e, CH_SLASH);
      if (mode_step == MODE_WORD || mode_step == MODE_STR || mode_step == MODE_STR_ESC) begin
        e = put(e, EV_END, 8'd0, oc_step, 1'b0);
      end
      e = put(e, EV_EOS, 8'd0, CLS_STRING, 1'b0);
    end
    entry = e;
  end

  assign push = acc && (entry.cnt != '0);

  a_eos_reset: assert property (@(posedge clk) disable iff (rst)
    (acc && end_of_input) |=> (mode == MODE_NORMAL && !sp && oc == CLS_STRING))
    else $error("lexer state not cleared after end of stream");

  a_eos_push: assert property (@(posedge clk) disable iff (rst)
    (acc && end_of_input) |-> push)
    else $error("end of stream produced no words");

endmodule

// ===== sv/tmt_queue.sv =====
// Short register queue of per-byte word lists between front and back end.
// Depends on tmt_pkg for the entry type.
module tmt_queue import tmt_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_entry,
  input  logic   pop,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  entry_t              store [DEPTH];
  logic [PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [CNT_QW-1:0]   fill;

  function automatic logic [PTR_W-1:0] inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= inc(wr_ptr);
      if (pop) rd_ptr <= inc(rd_ptr);
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= wr_entry;
  end

  assign head  = store[rd_ptr];
  assign full  = (fill == CNT_QW'(DEPTH));
  assign empty = (fill == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

endmodule

// ===== sv/tmt_back.sv =====
// Back end of the tokenizer: walks one queued word list, one word a cycle while m_tready is high.
// Depends on tmt_pkg.
module tmt_back import tmt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  entry_t     head,
  input  logic       empty,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output res_t       word,
  output logic       last
);

  logic [CNT_W-1:0] idx;

  assign m_tvalid = !empty;
  assign word     = head.res[idx];
  assign last     = (idx == head.cnt - 1'b1);
  assign pop      = m_tvalid && m_tready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (m_tvalid && m_tready) begin
      idx <= last ? '0 : idx + 1'b1;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (idx < head.cnt && head.cnt <= CNT_W'(MAX_RES)))
    else $error("word index beyond queued list");

endmodule

// ===== sv/text_map_tokenizer.sv =====
// Text map tokenizer: one text byte in per cycle while the queue has room, a stream of token words out.
// Whitespace and both comment styles are dropped; each token byte leaves as
// its own word, an end word closes each token, and the flagged last byte of the
// stream adds an end-of-stream word. A byte is taken every cycle while the
// internal queue has room; one byte gives zero to five words and the output
// moves one word a cycle while m_tready is high, so sustained input rate is one
// byte per cycle for bytes that give at most one word and otherwise set by the output port.
// Depends on tmt_pkg, tmt_front, tmt_queue and tmt_back.
module text_map_tokenizer import tmt_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,  // [7:0] data_byte
  input  logic       s_tlast,  // end_of_input
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,  // [7:0] token_byte
  output logic [4:0] m_tuser,  // [1:0] event_res, [3:2] token_class, [4] token_first
  output logic       m_tlast   // last_of_run
);

  logic   acc, push, pop, full, empty;
  entry_t entry, head;
  res_t   word;

  assign s_tready = !full;
  assign acc      = s_tvalid && s_tready;

  tmt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .acc          (acc),
    .data_byte    (s_tdata),
    .end_of_input (s_tlast),
    .push         (push),
    .entry        (entry)
  );

  tmt_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (entry),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  tmt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .word     (word),
    .last     (m_tlast)
  );

  assign m_tdata = word.tbyte;
  assign m_tuser = {word.first, word.cls, word.ev};

endmodule
